@@ rtl/core/psc_pkg.sv @@
// Package for the plane-sweep SSD cost and winner-take-all block.
// Holds field widths, constants and the depth record type; no dependencies.
`default_nettype none

package psc_pkg;

    localparam int CHAN_W       = 8;
    localparam int ERR_W        = 32;
    localparam int ADD_W        = 28;
    localparam int DEPTH_W      = 8;
    localparam int VIEW_W       = 5;
    localparam int FRAC_W       = 8;
    localparam int DVD_W        = ERR_W + FRAC_W;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    localparam int MAX_DEPTHS_DEF = 256;
    localparam int MAX_VIEWS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [ADD_W-1:0]  OUT_PENALTY = ADD_W'(195075000);
    localparam logic [ERR_W-1:0]  ERR_OFFSET  = ERR_W'(1);
    localparam logic [ERR_W-1:0]  ERR_MAX     = '1;
    localparam logic [VIEW_W-1:0] VIEWS_RESET = VIEW_W'(2);
    localparam logic [VIEW_W-1:0] VIEWS_MIN   = VIEW_W'(2);

    // Word index of the num_views configuration register on the APB port.
    localparam logic IDX_NUM_VIEWS = 1'b0;

    typedef struct packed {
        logic [ERR_W-1:0]   err;
        logic [DEPTH_W-1:0] depth;
        logic               last_depth;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

@@ rtl/core/psc_in_if.sv @@
// Sample channel: valid/ready handshake with one reference and one neighbour pixel.
// Depends on psc_pkg for the channel widths.
`default_nettype none

interface psc_in_if;
    logic                        valid;
    logic                        ready;
    logic [psc_pkg::CHAN_W-1:0]  ref_red;
    logic [psc_pkg::CHAN_W-1:0]  ref_green;
    logic [psc_pkg::CHAN_W-1:0]  ref_blue;
    logic [psc_pkg::CHAN_W-1:0]  sample_red;
    logic [psc_pkg::CHAN_W-1:0]  sample_green;
    logic [psc_pkg::CHAN_W-1:0]  sample_blue;
    logic                        out_of_range;
    logic                        last_view;
    logic                        last_depth;

    modport source (
        output valid, ref_red, ref_green, ref_blue,
        output sample_red, sample_green, sample_blue,
        output out_of_range, last_view, last_depth,
        input  ready
    );
    modport sink (
        input  valid, ref_red, ref_green, ref_blue,
        input  sample_red, sample_green, sample_blue,
        input  out_of_range, last_view, last_depth,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/psc_out_if.sv @@
// Result channel: valid/ready handshake carrying one cost per depth.
// Depends on psc_pkg for the field widths.
`default_nettype none

interface psc_out_if;
    logic                        valid;
    logic                        ready;
    logic [psc_pkg::DEPTH_W-1:0] depth_index;
    logic [psc_pkg::ERR_W-1:0]   unary_cost;
    logic                        pixel_done;
    logic [psc_pkg::DEPTH_W-1:0] best_depth;

    modport source (
        output valid, depth_index, unary_cost, pixel_done, best_depth,
        input  ready
    );
    modport sink (
        input  valid, depth_index, unary_cost, pixel_done, best_depth,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/core/psc_fifo.sv @@
// Short flip-flop queue of closed-depth records between front and back.
// Depends on psc_pkg for the record and status types.
`default_nettype none

module psc_fifo #(
    parameter int DEPTH = psc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire psc_pkg::t_rec    i_data,
    input  wire logic             i_pop,
    output psc_pkg::t_rec         o_data,
    output psc_pkg::t_q_stat      o_stat
);
    import psc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_rec             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/psc_front.sv @@
// Front end: takes one sample a cycle unless stalled by a full queue,
// squares channel differences and accumulates the per-depth error;
// pushes a record when a depth closes. Depends on psc_pkg and psc_in_if.
`default_nettype none

module psc_front #(
    parameter int MAX_DEPTHS = psc_pkg::MAX_DEPTHS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    psc_in_if.sink             i_smp,
    input  wire psc_pkg::t_q_stat i_q_stat,
    output logic               o_push,
    output psc_pkg::t_rec      o_rec
);
    import psc_pkg::*;

    localparam int DEP_W = (MAX_DEPTHS > 1) ? $clog2(MAX_DEPTHS) : 1;

    function automatic logic [15:0] sq_diff(input logic [CHAN_W-1:0] a,
                                            input logic [CHAN_W-1:0] b);
        logic [CHAN_W-1:0] m;
        m = (a >= b) ? (a - b) : (b - a);
        return {8'b0, m} * {8'b0, m};
    endfunction

    logic [ADD_W-1:0] n_add;
    logic [ADD_W-1:0] r_a_add;
    logic             r_a_vld, r_a_lv, r_a_ld;
    logic             a_take;
    logic [ERR_W-1:0] r_err;
    logic [ERR_W:0]   sum_wide;
    logic [ERR_W-1:0] sum_sat;
    logic [DEP_W-1:0] r_dep;

    always_comb begin
        if (i_smp.out_of_range) begin
            n_add = OUT_PENALTY;
        end else begin
            n_add = ADD_W'({2'b0, sq_diff(i_smp.ref_red,   i_smp.sample_red)})
                  + ADD_W'({2'b0, sq_diff(i_smp.ref_green, i_smp.sample_green)})
                  + ADD_W'({2'b0, sq_diff(i_smp.ref_blue,  i_smp.sample_blue)});
        end
    end

    // A closing sample waits in the first stage while the queue is full.
    assign a_take      = r_a_vld && (!r_a_lv || !i_q_stat.full);
    assign i_smp.ready = !r_a_vld || a_take;

    assign sum_wide = {1'b0, r_err} + (ERR_W + 1)'(r_a_add);
    assign sum_sat  = sum_wide[ERR_W] ? ERR_MAX : sum_wide[ERR_W-1:0];

    assign o_push           = a_take && r_a_lv;
    assign o_rec.err        = sum_sat;
    assign o_rec.depth      = DEPTH_W'(r_dep);
    assign o_rec.last_depth = r_a_ld;

    always_ff @(posedge i_clk) begin
        if (i_smp.valid && i_smp.ready) begin
            r_a_add <= n_add;
            r_a_lv  <= i_smp.last_view;
            r_a_ld  <= i_smp.last_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_err   <= ERR_OFFSET;
            r_dep   <= '0;
        end else begin
            if (i_smp.ready) begin
                r_a_vld <= i_smp.valid;
            end
            if (a_take) begin
                if (r_a_lv) begin
                    r_err <= ERR_OFFSET;
                    if (r_a_ld || r_dep == DEP_W'(MAX_DEPTHS - 1)) begin
                        r_dep <= '0;
                    end else begin
                        r_dep <= r_dep + DEP_W'(1);
                    end
                end else begin
                    r_err <= sum_sat;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/psc_back.sv @@
// Back end: pops closed depths, tracks the first minimum and scales the
// error by 256 / (3 * views) with a bit-serial restoring divider.
// Depends on psc_pkg and psc_out_if.
`default_nettype none

module psc_back #(
    parameter int MAX_VIEWS = psc_pkg::MAX_VIEWS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [psc_pkg::VIEW_W-1:0] i_num_views,
    input  wire psc_pkg::t_rec             i_rec,
    input  wire psc_pkg::t_q_stat          i_q_stat,
    output logic                           o_pop,
    psc_out_if.source                      o_res
);
    import psc_pkg::*;

    localparam int DIV_W = $clog2(3 * MAX_VIEWS + 1);
    localparam int CNT_W = $clog2(DVD_W);
    localparam logic [VIEW_W-1:0] VIEWS_MAX = VIEW_W'(MAX_VIEWS);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_HOLD = 3'b100
    } t_bstate;

    t_bstate            r_state;
    logic [VIEW_W-1:0]  views;
    logic [DIV_W-1:0]   divisor;
    logic [ERR_W-1:0]   r_min_err;
    logic [DEPTH_W-1:0] r_min_dep;
    logic               take_min;
    logic [DEPTH_W-1:0] best_now;
    logic [DIV_W-1:0]   r_div;
    logic [DIV_W-1:0]   r_rem;
    logic [DVD_W-1:0]   r_dq;
    logic [CNT_W-1:0]   r_cnt;
    logic [DIV_W:0]     trial;
    logic               fits;
    logic [DEPTH_W-1:0] r_dep_out;
    logic               r_ld;
    logic [DEPTH_W-1:0] r_best;
    logic               r_o_vld;
    logic               out_free;

    always_comb begin
        if (i_num_views < VIEWS_MIN) begin
            views = VIEWS_MIN;
        end else if (i_num_views > VIEWS_MAX) begin
            views = VIEWS_MAX;
        end else begin
            views = i_num_views;
        end
    end

    assign divisor  = DIV_W'({views, 1'b0}) + DIV_W'(views);
    assign o_pop    = (r_state == S_IDLE) && !i_q_stat.empty;
    assign take_min = (i_rec.depth == '0) || (i_rec.err < r_min_err);
    assign best_now = take_min ? i_rec.depth : r_min_dep;

    assign trial = {r_rem, r_dq[DVD_W-1]};
    assign fits  = (trial >= {1'b0, r_div});

    assign out_free    = !r_o_vld || o_res.ready;
    assign o_res.valid = r_o_vld;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_div     <= divisor;
            r_rem     <= '0;
            r_dq      <= {i_rec.err, FRAC_W'(0)};
            r_dep_out <= i_rec.depth;
            r_ld      <= i_rec.last_depth;
            r_best    <= i_rec.last_depth ? best_now : '0;
        end else if (r_state == S_DIV) begin
            r_rem <= fits ? DIV_W'(trial - {1'b0, r_div}) : DIV_W'(trial);
            r_dq  <= {r_dq[DVD_W-2:0], fits};
        end
        if (r_state == S_HOLD && out_free) begin
            o_res.depth_index <= r_dep_out;
            o_res.unary_cost  <= (|r_dq[DVD_W-1:ERR_W]) ? ERR_MAX : r_dq[ERR_W-1:0];
            o_res.pixel_done  <= r_ld;
            o_res.best_depth  <= r_best;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_min_err <= ERR_MAX;
            r_min_dep <= '0;
            r_o_vld   <= 1'b0;
        end else begin
            if (r_state == S_HOLD && out_free) begin
                r_o_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_o_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                        // The minimum starts afresh once a pixel has closed.
                        if (i_rec.last_depth) begin
                            r_min_err <= ERR_MAX;
                            r_min_dep <= '0;
                        end else if (take_min) begin
                            r_min_err <= i_rec.err;
                            r_min_dep <= i_rec.depth;
                        end
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DVD_W - 1)) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/plane_sweep_ssd_cost_argmin.sv @@
// Top level of the plane-sweep SSD cost and winner-take-all block.
// Depends on psc_pkg, psc_in_if, psc_out_if, psc_fifo, psc_front, psc_back.
//
//  Channel   Direction  Handshake            Carries
//  i_smp     in         valid/ready          reference and neighbour RGB, flags
//  o_res     out        valid/ready          depth, scaled cost, done, best depth
//  APB       in/out     psel/penable/pready  num_views at byte address 0
//
// The front takes one sample per cycle; a closing sample enters a four-deep queue
// and waits while that queue is full. For each depth the back pops the record and
// updates the minimum, runs the bit-serial divide of the 40-bit scaled error, then
// loads the output before it pops again; if depths close faster the front stalls.
// Reset is synchronous and active low.
`default_nettype none

module plane_sweep_ssd_cost_argmin #(
    parameter int MAX_DEPTHS = psc_pkg::MAX_DEPTHS_DEF,
    parameter int MAX_VIEWS  = psc_pkg::MAX_VIEWS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    psc_in_if.sink                             i_smp,
    psc_out_if.source                          o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [psc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [psc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [psc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import psc_pkg::*;

    logic [VIEW_W-1:0] r_num_views;
    logic              cfg_wr;
    logic              push, pop;
    t_rec              rec_in, rec_out;
    t_q_stat           q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == IDX_NUM_VIEWS)
                  ? APB_DATA_W'(r_num_views) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_views <= VIEWS_RESET;
        end else if (cfg_wr && paddr[2] == IDX_NUM_VIEWS) begin
            r_num_views <= pwdata[VIEW_W-1:0];
        end
    end

    psc_front #(
        .MAX_DEPTHS (MAX_DEPTHS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_rec    (rec_in)
    );

    psc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .i_pop   (pop),
        .o_data  (rec_out),
        .o_stat  (q_stat)
    );

    psc_back #(
        .MAX_VIEWS (MAX_VIEWS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_views (r_num_views),
        .i_rec       (rec_out),
        .i_q_stat    (q_stat),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
